// ----- rtl/core/fws_pkg.sv -----
// Package for the keypoint window search block.
// Holds the shared widths, status codes and the command type passed from
// the front end to the back end. No dependencies.
package fws_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_W          = 13;
    localparam int COORD_W        = 17;
    localparam int RADIUS_W       = 16;
    localparam int BOUND_W        = 19;
    localparam int PIX_W          = 15;
    localparam int IDX_W          = 6;
    localparam int STATUS_W       = 2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OFF  = 2'd2;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;

    typedef struct packed {
        logic                      is_query;
        logic                      off;
        logic                      new_set;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [BOUND_W-1:0] minx16;
        logic signed [BOUND_W-1:0] maxx16;
        logic signed [BOUND_W-1:0] miny16;
        logic signed [BOUND_W-1:0] maxy16;
    } cmd_t;

endpackage

// ----- rtl/core/feature_window_search.sv -----
// Top level of the keypoint window search block.
// Connects the front end, the command queue and the back end.
// Depends on fws_pkg, fws_front, fws_queue and fws_back.
//
//   Channel   Handshake              Beat
//   input     in_valid / in_stall    func, point_x, point_y, radius_x, radius_y, new_set
//   output    out_valid / out_stall  point_index, hit, last, status
//   config    cfg_we                 cfg_index, cfg_data
//
// A load is handled in the back end and gives one result beat.
// With the output free, a query is answered by the scan, which reads one stored point
// per cycle from the keypoint memory; off-image queries give a single result beat.
// The front end is combinational, so an accepted beat is registered only in the queue,
// which holds two commands.
// Reset empties the store and the queue and loads the default image size.
// A stalled output can hold the scan; the input stalls only when the queue is full.
module feature_window_search
    import fws_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      func,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic [RADIUS_W-1:0]       radius_x,
    input  logic [RADIUS_W-1:0]       radius_y,
    input  logic                      new_set,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [IDX_W-1:0]          point_index,
    output logic                      hit,
    output logic                      last,
    output logic [STATUS_W-1:0]       status
);

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic q_full;
    logic q_not_empty;
    logic q_pop;

    assign in_stall = q_full;

    fws_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .func      (func),
        .point_x   (point_x),
        .point_y   (point_y),
        .radius_x  (radius_x),
        .radius_y  (radius_y),
        .new_set   (new_set),
        .cmd       (front_cmd)
    );

    fws_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_cmd)
    );

    fws_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_not_empty),
        .cmd         (head_cmd),
        .cmd_pop     (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .point_index (point_index),
        .hit         (hit),
        .last        (last),
        .status      (status)
    );

endmodule

// ----- rtl/core/fws_front.sv -----
// Front end: image size registers and classification of each input beat.
// Turns a query into clamped window bounds and an off-image flag.
// Depends on fws_pkg.
module fws_front
    import fws_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      func,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic [RADIUS_W-1:0]       radius_x,
    input  logic [RADIUS_W-1:0]       radius_y,
    input  logic                      new_set,
    output cmd_t                      cmd
);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    logic signed [BOUND_W-1:0] dlx, dhx, dly, dhy;
    logic signed [PIX_W-1:0]   tlx, thx, tly, thy;
    logic signed [PIX_W-1:0]   minx, maxx, miny, maxy;
    logic signed [PIX_W-1:0]   w_s, h_s, wm1, hm1;

    function automatic logic signed [PIX_W-1:0] trunc16(input logic signed [BOUND_W-1:0] d);
        logic signed [BOUND_W-1:0] t;
        logic signed [PIX_W-1:0]   q;
        t = d >>> 4;
        q = t[PIX_W-1:0];
        if (d[BOUND_W-1] && (d[3:0] != 4'd0))
        begin
            q = q + 15'sd1;
        end
        return q;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else
            begin
                height_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        dlx = BOUND_W'(point_x) - $signed({3'b000, radius_x});
        dhx = BOUND_W'(point_x) + $signed({3'b000, radius_x});
        dly = BOUND_W'(point_y) - $signed({3'b000, radius_y});
        dhy = BOUND_W'(point_y) + $signed({3'b000, radius_y});
        tlx = trunc16(dlx);
        thx = trunc16(dhx);
        tly = trunc16(dly);
        thy = trunc16(dhy);
        w_s = $signed({2'b00, width_reg});
        h_s = $signed({2'b00, height_reg});
        wm1 = w_s - 15'sd1;
        hm1 = h_s - 15'sd1;
        minx = (tlx > 15'sd0) ? tlx : 15'sd0;
        miny = (tly > 15'sd0) ? tly : 15'sd0;
        maxx = (thx < wm1) ? thx : wm1;
        maxy = (thy < hm1) ? thy : hm1;

        cmd.is_query = func;
        cmd.off      = (minx >= w_s) || (maxx < 15'sd0) || (miny >= h_s) || (maxy < 15'sd0);
        cmd.new_set  = new_set;
        cmd.px       = point_x;
        cmd.py       = point_y;
        cmd.minx16   = $signed({minx, 4'b0000});
        cmd.maxx16   = $signed({maxx, 4'b0000});
        cmd.miny16   = $signed({miny, 4'b0000});
        cmd.maxy16   = $signed({maxy, 4'b0000});
    end

endmodule

// ----- rtl/core/fws_queue.sv -----
// Short command queue between the front end and the back end.
// Pushes on request (the top level gates push with full), pops on request from the back end.
// Depends on fws_pkg.
module fws_queue
    import fws_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;

    assign full      = (fill_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/core/fws_back.sv -----
// Back end: keypoint store, load handling and the window scan.
// Scans one stored point per cycle unless a stalled output holds the scan, and drives the registered output beat.
// Depends on fws_pkg.
module fws_back
    import fws_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    output logic                cmd_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [IDX_W-1:0]    point_index,
    output logic                hit,
    output logic                last,
    output logic [STATUS_W-1:0] status
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;

    logic signed [COORD_W-1:0] mem_x [MAX_POINTS];
    logic signed [COORD_W-1:0] mem_y [MAX_POINTS];

    logic [1:0]                state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             scan_reg, scan_next;
    logic                      s2_valid_reg, s2_valid_next;
    logic [AW-1:0]             s2_idx_reg;
    logic signed [COORD_W-1:0] rdx_reg, rdy_reg;
    logic                      hold_valid_reg, hold_valid_next;
    logic [AW-1:0]             hold_idx_reg, hold_idx_next;
    logic signed [BOUND_W-1:0] minx_reg, maxx_reg, miny_reg, maxy_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]          out_idx_reg, out_idx_next;
    logic                      out_hit_reg, out_hit_next;
    logic                      out_last_reg, out_last_next;
    logic [STATUS_W-1:0]       out_status_reg, out_status_next;

    logic          out_free;
    logic          issuing;
    logic          advance;
    logic          s2_match;
    logic          start_query;
    logic          do_write;
    logic [CW-1:0] eff_count;
    logic signed [BOUND_W-1:0] sx, sy;

    assign out_valid   = out_valid_reg;
    assign point_index = out_idx_reg;
    assign hit         = out_hit_reg;
    assign last        = out_last_reg;
    assign status      = out_status_reg;

    assign out_free  = !out_valid_reg || !out_stall;
    assign issuing   = (state_reg == S_SCAN) && (scan_reg < count_reg);
    assign sx        = BOUND_W'(rdx_reg);
    assign sy        = BOUND_W'(rdy_reg);
    assign s2_match  = (sx > minx_reg) && (sx < maxx_reg) && (sy > miny_reg) && (sy < maxy_reg);
    assign advance   = !s2_valid_reg || !s2_match || !hold_valid_reg || out_free;
    assign eff_count = cmd.new_set ? '0 : count_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        s2_valid_next   = s2_valid_reg;
        hold_valid_next = hold_valid_reg;
        hold_idx_next   = hold_idx_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_idx_next    = out_idx_reg;
        out_hit_next    = out_hit_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        cmd_pop         = 1'b0;
        start_query     = 1'b0;
        do_write        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && cmd.is_query && !cmd.off)
                begin
                    cmd_pop         = 1'b1;
                    start_query     = 1'b1;
                    state_next      = S_SCAN;
                    scan_next       = '0;
                    s2_valid_next   = 1'b0;
                    hold_valid_next = 1'b0;
                end
                else if (cmd_valid && out_free)
                begin
                    cmd_pop        = 1'b1;
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (cmd.is_query)
                    begin
                        out_idx_next    = '0;
                        out_hit_next    = 1'b0;
                        out_status_next = ST_OFF;
                    end
                    else if (eff_count >= CW'(MAX_POINTS))
                    begin
                        out_idx_next    = '0;
                        out_hit_next    = 1'b0;
                        out_status_next = ST_FULL;
                    end
                    else
                    begin
                        do_write        = 1'b1;
                        count_next      = eff_count + 1'b1;
                        out_idx_next    = IDX_W'(eff_count);
                        out_hit_next    = 1'b1;
                        out_status_next = ST_OK;
                    end
                end
            end
            S_SCAN:
            begin
                if (advance)
                begin
                    s2_valid_next = issuing;
                    if (issuing)
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                    if (s2_valid_reg && s2_match)
                    begin
                        hold_valid_next = 1'b1;
                        hold_idx_next   = s2_idx_reg;
                        if (hold_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_idx_next    = IDX_W'(hold_idx_reg);
                            out_hit_next    = 1'b1;
                            out_last_next   = 1'b0;
                            out_status_next = ST_OK;
                        end
                    end
                end
                if (!issuing && !s2_valid_reg && out_free)
                begin
                    state_next      = S_IDLE;
                    hold_valid_next = 1'b0;
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    out_status_next = ST_OK;
                    out_hit_next    = hold_valid_reg;
                    out_idx_next    = hold_valid_reg ? IDX_W'(hold_idx_reg) : '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            scan_reg       <= '0;
            s2_valid_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scan_reg       <= scan_next;
            s2_valid_reg   <= s2_valid_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_idx_reg   <= hold_idx_next;
        out_idx_reg    <= out_idx_next;
        out_hit_reg    <= out_hit_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
        if (start_query)
        begin
            minx_reg <= cmd.minx16;
            maxx_reg <= cmd.maxx16;
            miny_reg <= cmd.miny16;
            maxy_reg <= cmd.maxy16;
        end
        if ((state_reg == S_SCAN) && advance && issuing)
        begin
            rdx_reg    <= mem_x[scan_reg[AW-1:0]];
            rdy_reg    <= mem_y[scan_reg[AW-1:0]];
            s2_idx_reg <= scan_reg[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem_x[eff_count[AW-1:0]] <= cmd.px;
            mem_y[eff_count[AW-1:0]] <= cmd.py;
        end
    end

endmodule
